// ----- hdl/xcbc_pkg.sv -----
// ----------------------------------------------------------------------------
// XTEA counter-mode byte cipher: shared definitions
// Types and constants shared by the front end, the keystream generator and
// the back end of the byte cipher.
// ----------------------------------------------------------------------------
package xcbc_pkg;

	localparam int BYTE_W      = 8;
	localparam int WORD_W      = 32;
	localparam int BLOCK_W     = 64;
	localparam int POS_W       = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int RING_SLOTS  = 8;

	localparam logic [POS_W-1:0]  BLOCK_BYTES = POS_W'(8);
	localparam logic [WORD_W-1:0] XTEA_DELTA  = 32'h9E37_79B9;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_0,
		REG_KEY_1,
		REG_KEY_2,
		REG_KEY_3
	} cfg_reg_t;

	typedef struct packed {
		logic              we;
		cfg_reg_t          idx;
		logic [WORD_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              new_blk;
		logic [2:0]        pos;
	} item_t;

endpackage

// ----- hdl/xcbc_in_if.sv -----
// ----------------------------------------------------------------------------
// Input byte channel
// Valid/ready channel that carries one data byte per transaction.
// ----------------------------------------------------------------------------
interface xcbc_in_if;

	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);

endinterface

// ----- hdl/xcbc_out_if.sv -----
// ----------------------------------------------------------------------------
// Output byte channel
// Valid/ready channel that carries one ciphered byte per transaction.
// ----------------------------------------------------------------------------
interface xcbc_out_if;

	logic       valid;
	logic       ready;
	logic [7:0] out_byte;

	modport source (output valid, output out_byte, input ready);
	modport sink   (input valid, input out_byte, output ready);

endinterface

// ----- hdl/xcbc_fifo.sv -----
// ----------------------------------------------------------------------------
// Small register FIFO
// First-in first-out queue in flip-flops with a synchronous clear.
// ----------------------------------------------------------------------------
module xcbc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else if (clear) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("FIFO occupancy exceeds its depth");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty && !clear |-> !pop)
		else $error("FIFO popped while empty");
`endif

endmodule

// ----- hdl/xcbc_front.sv -----
// ----------------------------------------------------------------------------
// Byte cipher front end
// Accepts data bytes, tags each with its keystream byte position and marks
// the bytes that open a new keystream block.
// ----------------------------------------------------------------------------
module xcbc_front (
	input  logic              clk,
	input  logic              arst_n,
	xcbc_in_if.sink           in_ch,
	output logic              push,
	output xcbc_pkg::item_t   push_item,
	input  logic              full
);

	import xcbc_pkg::*;

	logic [POS_W-1:0] byte_pos_q;
	logic             new_blk;

	assign new_blk     = (byte_pos_q >= BLOCK_BYTES);
	assign in_ch.ready = !full;
	assign push        = in_ch.valid && !full;

	always_comb begin
		push_item.data    = in_ch.data_byte;
		push_item.new_blk = new_blk;
		push_item.pos     = new_blk ? 3'd0 : byte_pos_q[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= BLOCK_BYTES;
		end else if (push) begin
			byte_pos_q <= new_blk ? POS_W'(1) : byte_pos_q + 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (byte_pos_q >= POS_W'(1)) && (byte_pos_q <= BLOCK_BYTES))
		else $error("Byte position left its range after a transaction");
`endif

endmodule

// ----- hdl/xcbc_gen.sv -----
// ----------------------------------------------------------------------------
// XTEA keystream generator
// Encrypts successive counter values in a ring of eight half-round stages
// and queues the finished keystream blocks in counter order.
// ----------------------------------------------------------------------------
module xcbc_gen #(
	parameter int ROUND_COUNT = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  xcbc_pkg::cfg_wr_t              cfg,
	output logic                           blk_valid,
	output logic [xcbc_pkg::BLOCK_W-1:0]   blk_data,
	input  logic                           blk_pop
);

	import xcbc_pkg::*;

	localparam int STEPS  = 2 * ROUND_COUNT;
	localparam int STEP_W = $clog2(STEPS + 1);
	localparam int SEQ_W  = $clog2(RING_SLOTS) + 1;

	typedef logic [3:0][WORD_W-1:0] key_t;

	typedef struct packed {
		logic              valid;
		logic [SEQ_W-1:0]  seq;
		logic [STEP_W-1:0] step;
		logic [WORD_W-1:0] s;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} slot_t;

	function automatic slot_t half_round(slot_t x, key_t k);
		slot_t             y;
		logic [WORD_W-1:0] kw;
		logic [WORD_W-1:0] mixv;
		y    = x;
		kw   = '0;
		mixv = '0;
		if (x.valid && (x.step != STEP_W'(STEPS))) begin
			if (!x.step[0]) begin
				kw   = k[x.s[1:0]];
				mixv = ((x.b << 4) ^ (x.b >> 5)) + x.b;
				y.a  = x.a + (mixv ^ (x.s + kw));
				y.s  = x.s + XTEA_DELTA;
			end else begin
				kw   = k[x.s[12:11]];
				mixv = ((x.a << 4) ^ (x.a >> 5)) + x.a;
				y.b  = x.b + (mixv ^ (x.s + kw));
			end
			y.step = x.step + 1'b1;
		end
		return y;
	endfunction

	key_t               key_q;
	slot_t              slot_q   [RING_SLOTS];
	slot_t              slot_nxt [RING_SLOTS];
	slot_t              new_slot;
	logic [BLOCK_W-1:0] gen_ctr_q;
	logic [BLOCK_W-1:0] cons_ctr_q;
	logic [SEQ_W-1:0]   issue_seq_q;
	logic [SEQ_W-1:0]   exit_seq_q;
	logic [RING_SLOTS-1:0] ring_valid;
	logic               bf_full;
	logic               bf_empty;
	logic               leave;
	logic               insert;
	slot_t              tail;
	slot_t              tail_done;

	assign tail      = slot_q[RING_SLOTS-1];
	assign tail_done = half_round(tail, key_q);
	assign leave     = tail.valid && (tail_done.step == STEP_W'(STEPS)) &&
	                   (tail.seq == exit_seq_q) && !bf_full;
	assign insert    = !tail.valid || leave;

	always_comb begin
		new_slot.valid = 1'b1;
		new_slot.seq   = issue_seq_q;
		new_slot.step  = '0;
		new_slot.s     = '0;
		new_slot.a     = gen_ctr_q[WORD_W-1:0];
		new_slot.b     = gen_ctr_q[BLOCK_W-1:WORD_W];
		slot_nxt[0]    = insert ? new_slot : tail_done;
		for (int i = 1; i < RING_SLOTS; i++) begin
			slot_nxt[i] = half_round(slot_q[i-1], key_q);
		end
		for (int i = 0; i < RING_SLOTS; i++) begin
			ring_valid[i] = slot_q[i].valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q       <= '0;
			gen_ctr_q   <= '0;
			cons_ctr_q  <= '0;
			issue_seq_q <= '0;
			exit_seq_q  <= '0;
			for (int i = 0; i < RING_SLOTS; i++) begin
				slot_q[i] <= '0;
			end
		end else begin
			if (blk_pop) begin
				cons_ctr_q <= cons_ctr_q + 1'b1;
			end
			if (cfg.we) begin
				unique case (cfg.idx)
					REG_KEY_0: key_q[0] <= cfg.data;
					REG_KEY_1: key_q[1] <= cfg.data;
					REG_KEY_2: key_q[2] <= cfg.data;
					REG_KEY_3: key_q[3] <= cfg.data;
				endcase
				gen_ctr_q   <= cons_ctr_q + BLOCK_W'(blk_pop);
				issue_seq_q <= '0;
				exit_seq_q  <= '0;
				for (int i = 0; i < RING_SLOTS; i++) begin
					slot_q[i] <= '0;
				end
			end else begin
				if (insert) begin
					gen_ctr_q   <= gen_ctr_q + 1'b1;
					issue_seq_q <= issue_seq_q + 1'b1;
				end
				if (leave) begin
					exit_seq_q <= exit_seq_q + 1'b1;
				end
				for (int i = 0; i < RING_SLOTS; i++) begin
					slot_q[i] <= slot_nxt[i];
				end
			end
		end
	end

	xcbc_fifo #(
		.WIDTH (BLOCK_W),
		.DEPTH (2)
	) u_blk_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (cfg.we),
		.push      (leave),
		.push_data ({tail_done.b, tail_done.a}),
		.full      (bf_full),
		.pop       (blk_pop),
		.pop_data  (blk_data),
		.empty     (bf_empty)
	);

	assign blk_valid = !bf_empty;

`ifndef ASSERT_OFF
	a_flush_empties_ring: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.we |=> (ring_valid == '0) && !blk_valid)
		else $error("Key write did not discard the blocks in flight");

	a_leave_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		leave && !cfg.we |=> exit_seq_q == $past(exit_seq_q) + 1'b1)
		else $error("Block sequence did not advance on leaving the ring");
`endif

endmodule

// ----- hdl/xcbc_back.sv -----
// ----------------------------------------------------------------------------
// Byte cipher back end
// Combines queued data bytes with keystream bytes and holds the result in
// an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module xcbc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  xcbc_pkg::item_t               item,
	output logic                          item_pop,
	input  logic                          blk_valid,
	input  logic [xcbc_pkg::BLOCK_W-1:0]  blk_data,
	output logic                          blk_pop,
	xcbc_out_if.source                    out_ch
);

	import xcbc_pkg::*;

	logic [BLOCK_W-1:0] cur_blk_q;
	logic [BLOCK_W-1:0] src_blk;
	logic [BYTE_W-1:0]  ks_byte;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               out_valid_q;
	logic               go;

	assign go       = item_valid && (!item.new_blk || blk_valid) &&
	                  (!out_valid_q || out_ch.ready);
	assign item_pop = go;
	assign blk_pop  = go && item.new_blk;
	assign src_blk  = item.new_blk ? blk_data : cur_blk_q;
	assign ks_byte  = src_blk[{item.pos, 3'b000} +: BYTE_W];

	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_byte = out_byte_q;

	always_ff @(posedge clk) begin
		if (go) begin
			out_byte_q <= item.data ^ ks_byte;
			if (item.new_blk) begin
				cur_blk_q <= blk_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- hdl/xtea_ctr_byte_cipher.sv -----
// ----------------------------------------------------------------------------
// XTEA counter-mode byte cipher
// Each transaction on in_ch carries one byte; the matching transaction on
// out_ch returns that byte XORed with the next XTEA counter-mode keystream
// byte, low word of each block first, low byte first.
// The four key words are written through cfg_we, cfg_idx and cfg_wdata
// while the block is idle; a write discards prefetched keystream blocks and
// restarts generation from the next unused counter value. The block being
// consumed is kept.
// When keystream is ready, each byte passes through the item queue and the
// output register. Keystream comes from a ring of eight half-round stages:
// a block needs ceil(2*ROUND_COUNT/8) laps, so for ROUND_COUNT up to 32 the
// ring keeps pace with one byte per cycle while out_ch does not stall.
// After reset or a key write, bytes that need the first block wait until it
// has left the ring.
// Reset clears the key, the counter and the queues. When out_ch stalls the
// output register holds its byte and two further bytes are queued before
// in_ch.ready falls.
// ----------------------------------------------------------------------------
module xtea_ctr_byte_cipher #(
	parameter int ROUND_COUNT = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [xcbc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [xcbc_pkg::WORD_W-1:0]     cfg_wdata,
	xcbc_in_if.sink                         in_ch,
	xcbc_out_if.source                      out_ch
);

	import xcbc_pkg::*;

	localparam int ITEM_W = $bits(item_t);

	cfg_wr_t            cfg;
	logic               push;
	item_t              push_item;
	logic               iq_full;
	logic               iq_empty;
	logic [ITEM_W-1:0]  iq_data;
	item_t              pop_item;
	logic               item_pop;
	logic               blk_valid;
	logic [BLOCK_W-1:0] blk_data;
	logic               blk_pop;

	always_comb begin
		cfg.we   = cfg_we;
		cfg.idx  = cfg_reg_t'(cfg_idx);
		cfg.data = cfg_wdata;
	end

	assign pop_item = item_t'(iq_data);

	xcbc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.push      (push),
		.push_item (push_item),
		.full      (iq_full)
	);

	xcbc_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (2)
	) u_item_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (1'b0),
		.push      (push),
		.push_data (push_item),
		.full      (iq_full),
		.pop       (item_pop),
		.pop_data  (iq_data),
		.empty     (iq_empty)
	);

	xcbc_gen #(
		.ROUND_COUNT (ROUND_COUNT)
	) u_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.blk_valid (blk_valid),
		.blk_data  (blk_data),
		.blk_pop   (blk_pop)
	);

	xcbc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (!iq_empty),
		.item       (pop_item),
		.item_pop   (item_pop),
		.blk_valid  (blk_valid),
		.blk_data   (blk_data),
		.blk_pop    (blk_pop),
		.out_ch     (out_ch)
	);

endmodule
